// File: hdl/mted_pkg.sv
// shared types and constants for the midi timed event dispatcher
package mted_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam logic [7:0] TEMPO_META = 8'h51;
	localparam logic [6:0] VEL_MAX = 7'd127;
	localparam logic [23:0] TEMPO_MAX = 24'hFFFFFF;

	localparam logic [1:0] REQ_ENQ = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [2:0] KIND_ACCEPTED = 3'd0;
	localparam logic [2:0] KIND_REJECTED = 3'd1;
	localparam logic [2:0] KIND_MESSAGE = 3'd2;
	localparam logic [2:0] KIND_TEMPO = 3'd3;
	localparam logic [2:0] KIND_CLEARED = 3'd4;

	localparam logic CFG_TEMPO_SCALE = 1'b0;
	localparam logic CFG_VELOCITY_SCALE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_EMIT_TEMPO
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic enq_write;
		logic emit_simple;
		logic [2:0] simple_kind;
		logic clear;
		logic mem_read;
		logic pop;
		logic emit_msg;
		logic div_start;
		logic emit_tempo;
		logic flush;
		logic emit_last;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req;
		logic full;
		logic empty;
		logic due;
		logic head_meta;
		logic head_tempo;
		logic div_done;
	} stat_t;

endpackage

// File: hdl/mted_datapath.sv
// queue storage, velocity scaling, tempo divider and result registers
module mted_datapath #(
	parameter int QUEUE_DEPTH = mted_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  mted_pkg::ctrl_t ctrl,
	output mted_pkg::stat_t stat,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0] req_type,
	input  logic [31:0] now_ticks,
	input  logic [31:0] time_ticks,
	input  logic is_absolute,
	input  logic [7:0] status_byte,
	input  logic [6:0] data_one,
	input  logic [6:0] data_two,
	input  logic is_meta,
	input  logic [7:0] meta_type,
	input  logic [23:0] meta_payload,
	output logic result_valid,
	output logic [2:0] result_kind,
	output logic [7:0] out_status,
	output logic [6:0] out_data_one,
	output logic [6:0] out_data_two,
	output logic [23:0] tempo_us,
	output logic [4:0] queue_count,
	output logic last
);
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [15:0] tempo_scale_q, velocity_scale_q;
	logic [1:0] req_q;
	logic [31:0] now_q, time_q;
	logic abs_q;
	logic [54:0] body_q;
	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [31:0] due_mem [QUEUE_DEPTH];
	logic [54:0] body_mem [QUEUE_DEPTH];
	logic [31:0] rd_due_q;
	logic [54:0] rd_body_q;

	// tempo divider: 32-bit dividend, one quotient bit a cycle
	logic [31:0] div_num_q, div_quo_q;
	logic [16:0] div_rem_q;
	logic [5:0] div_cnt_q;
	logic div_busy_q;
	logic [16:0] rem_shift;
	logic [32:0] due_sum;
	logic [31:0] due_val;
	logic [22:0] vel_prod;
	logic [14:0] vel_shr;
	logic [6:0] vel;
	logic [3:0] hi_nib;

	// drain word staging
	logic [2:0] stg_kind_q;
	logic [7:0] stg_status_q;
	logic [6:0] stg_d1_q;
	logic [6:0] stg_d2_q;
	logic [23:0] stg_tempo_q;
	logic [4:0] stg_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_scale_q <= 16'd256;
			velocity_scale_q <= 16'd256;
		end else if (cfg_we) begin
			if (cfg_index == mted_pkg::CFG_TEMPO_SCALE) tempo_scale_q <= cfg_data;
			else velocity_scale_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			req_q <= req_type;
			now_q <= now_ticks;
			time_q <= time_ticks;
			abs_q <= is_absolute;
			body_q <= {status_byte, data_one, data_two, is_meta, meta_type, meta_payload};
		end
	end

	assign due_sum = {1'b0, time_q} + {1'b0, now_q};
	assign due_val = abs_q ? time_q : (due_sum[32] ? 32'hFFFFFFFF : due_sum[31:0]);

	always_ff @(posedge clk) begin
		if (ctrl.enq_write) begin
			due_mem[tail_q] <= due_val;
			body_mem[tail_q] <= body_q;
		end
		if (ctrl.mem_read) begin
			rd_due_q <= due_mem[head_q];
			rd_body_q <= body_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (ctrl.enq_write) begin
			tail_q <= (tail_q == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop) begin
			head_q <= (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	assign stat.req = req_q;
	assign stat.full = (count_q == CW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.due = (rd_due_q <= now_q);
	assign stat.head_meta = rd_body_q[32];
	assign stat.head_tempo = (rd_body_q[31:24] == mted_pkg::TEMPO_META);
	assign stat.div_done = div_busy_q && (div_cnt_q == 6'd0);

	assign rem_shift = {div_rem_q[15:0], div_num_q[31]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (ctrl.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= 6'd32;
		end else if (ctrl.emit_tempo) begin
			div_busy_q <= 1'b0;
		end else if (div_busy_q && div_cnt_q != 6'd0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			div_num_q <= {rd_body_q[23:0], 8'd0};
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_busy_q && div_cnt_q != 6'd0) begin
			div_num_q <= {div_num_q[30:0], 1'b0};
			if (rem_shift >= {1'b0, tempo_scale_q}) begin
				div_rem_q <= rem_shift - {1'b0, tempo_scale_q};
				div_quo_q <= {div_quo_q[30:0], 1'b1};
			end else begin
				div_rem_q <= rem_shift;
				div_quo_q <= {div_quo_q[30:0], 1'b0};
			end
		end
	end

	assign hi_nib = rd_body_q[54:51];
	assign vel_prod = rd_body_q[39:33] * velocity_scale_q;
	assign vel_shr = vel_prod[22:8];
	assign vel = (vel_shr > 15'(mted_pkg::VEL_MAX)) ? mted_pkg::VEL_MAX : vel_shr[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= ctrl.emit_simple | ctrl.flush;
	end

	// queue_count after this word: pop/enq land on the same edge, so use next count
	always_ff @(posedge clk) begin
		if (ctrl.emit_msg) begin
			stg_kind_q <= mted_pkg::KIND_MESSAGE;
			stg_status_q <= rd_body_q[54:47];
			stg_d1_q <= rd_body_q[46:40];
			stg_d2_q <= (hi_nib == 4'd8 || hi_nib == 4'd9) ? vel : rd_body_q[39:33];
			stg_tempo_q <= '0;
			stg_count_q <= 5'(count_q - 1'b1);
		end else if (ctrl.emit_tempo) begin
			stg_kind_q <= mted_pkg::KIND_TEMPO;
			stg_status_q <= '0;
			stg_d1_q <= '0;
			stg_d2_q <= '0;
			stg_tempo_q <= (tempo_scale_q == '0 || div_quo_q[31:24] != '0)
				? mted_pkg::TEMPO_MAX : div_quo_q[23:0];
			stg_count_q <= 5'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		last <= ctrl.emit_last;
		out_status <= '0;
		out_data_one <= '0;
		out_data_two <= '0;
		tempo_us <= '0;
		if (ctrl.emit_simple) begin
			result_kind <= ctrl.simple_kind;
			if (ctrl.clear) queue_count <= '0;
			else if (ctrl.enq_write) queue_count <= 5'(count_q + 1'b1);
			else queue_count <= 5'(count_q);
		end else if (ctrl.flush) begin
			result_kind <= stg_kind_q;
			out_status <= stg_status_q;
			out_data_one <= stg_d1_q;
			out_data_two <= stg_d2_q;
			tempo_us <= stg_tempo_q;
			queue_count <= stg_count_q;
		end
	end
endmodule

// File: hdl/mted_controller.sv
// sequencer for enqueue, tick drain and clear requests
module mted_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  mted_pkg::stat_t stat,
	output mted_pkg::ctrl_t ctrl
);
	mted_pkg::state_t state_q, state_d;
	logic [4:0] nres_q, nres_d;
	logic pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mted_pkg::ST_IDLE;
			nres_q <= '0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			nres_q <= nres_d;
			pend_q <= pend_d;
		end
	end

	always_comb begin
		state_d = state_q;
		nres_d = nres_q;
		pend_d = pend_q;
		ctrl = '0;
		busy = (state_q != mted_pkg::ST_IDLE);
		unique case (state_q)
			mted_pkg::ST_IDLE: begin
				if (start) begin
					ctrl.latch = 1'b1;
					state_d = mted_pkg::ST_READ;
					nres_d = '0;
					pend_d = 1'b0;
				end
			end
			mted_pkg::ST_READ: begin
				// decode request; tick issues a head read
				state_d = mted_pkg::ST_IDLE;
				case (stat.req)
					mted_pkg::REQ_ENQ: begin
						ctrl.emit_simple = 1'b1;
						ctrl.emit_last = 1'b1;
						if (stat.full) ctrl.simple_kind = mted_pkg::KIND_REJECTED;
						else begin
							ctrl.simple_kind = mted_pkg::KIND_ACCEPTED;
							ctrl.enq_write = 1'b1;
						end
					end
					mted_pkg::REQ_CLEAR: begin
						ctrl.emit_simple = 1'b1;
						ctrl.emit_last = 1'b1;
						ctrl.simple_kind = mted_pkg::KIND_CLEARED;
						ctrl.clear = 1'b1;
					end
					mted_pkg::REQ_TICK: begin
						if (!stat.empty && nres_q != 5'(mted_pkg::MAX_RESULTS)) begin
							ctrl.mem_read = 1'b1;
							state_d = mted_pkg::ST_CHECK;
						end else if (pend_q) begin
							// drain over: the staged word is the final one
							ctrl.flush = 1'b1;
							ctrl.emit_last = 1'b1;
							pend_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
			mted_pkg::ST_CHECK: begin
				if (!stat.due) begin
					state_d = mted_pkg::ST_IDLE;
					if (pend_q) begin
						ctrl.flush = 1'b1;
						ctrl.emit_last = 1'b1;
						pend_d = 1'b0;
					end
				end else if (stat.head_meta && !stat.head_tempo) begin
					ctrl.pop = 1'b1;
					state_d = mted_pkg::ST_READ;
				end else if (stat.head_meta) begin
					ctrl.div_start = 1'b1;
					state_d = mted_pkg::ST_DIV;
				end else begin
					ctrl.pop = 1'b1;
					ctrl.emit_msg = 1'b1;
					ctrl.flush = pend_q;
					pend_d = 1'b1;
					nres_d = nres_q + 1'b1;
					state_d = mted_pkg::ST_READ;
				end
			end
			mted_pkg::ST_DIV: begin
				if (stat.div_done) begin
					ctrl.pop = 1'b1;
					ctrl.emit_tempo = 1'b1;
					ctrl.flush = pend_q;
					pend_d = 1'b1;
					nres_d = nres_q + 1'b1;
					state_d = mted_pkg::ST_READ;
				end
			end
			default: state_d = mted_pkg::ST_IDLE;
		endcase
	end
endmodule

// File: hdl/midi_timed_event_dispatcher_unit.sv
// top level of the midi timed event dispatcher
// A start pulse with busy low takes one request word: enqueue, tick or clear.
// Result words sit on the result ports for one cycle each, marked by
// result_valid; the receiver cannot stall them. last marks the final word
// of a request.
// Enqueue and clear give one word, formed in ST_READ and registered onto the
// ports; busy is high for one cycle, and a new request is taken back in idle.
// A tick walks the queue head: each head entry takes a memory read (ST_READ)
// and a due compare (ST_CHECK); a due message gives a word, a set-tempo meta adds
// a 32-step restoring divider, other metas are dropped.
// At most 16 words per tick; the rest stay queued for the next tick.
// Each drain word waits in a staging register until the next head is known:
// it leaves when the next word is formed, or with last set when the drain
// ends. A tick with nothing due gives no word.
// Reset clears the queue pointers and count (queue memory is left as is)
// and sets tempo_scale and velocity_scale to 256, unity in Q8.8.
// Configuration writes take effect at the next clock edge; write only while
// the block is idle.
module midi_timed_event_dispatcher_unit #(
	parameter int QUEUE_DEPTH = mted_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0] req_type,
	input  logic [31:0] now_ticks,
	input  logic [31:0] time_ticks,
	input  logic is_absolute,
	input  logic [7:0] status_byte,
	input  logic [6:0] data_one,
	input  logic [6:0] data_two,
	input  logic is_meta,
	input  logic [7:0] meta_type,
	input  logic [23:0] meta_payload,
	output logic result_valid,
	output logic [2:0] result_kind,
	output logic [7:0] out_status,
	output logic [6:0] out_data_one,
	output logic [6:0] out_data_two,
	output logic [23:0] tempo_us,
	output logic [4:0] queue_count,
	output logic last
);
	mted_pkg::ctrl_t ctrl;
	mted_pkg::stat_t stat;

	mted_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .ctrl(ctrl)
	);

	mted_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_type(req_type), .now_ticks(now_ticks), .time_ticks(time_ticks),
		.is_absolute(is_absolute), .status_byte(status_byte), .data_one(data_one),
		.data_two(data_two), .is_meta(is_meta), .meta_type(meta_type),
		.meta_payload(meta_payload), .result_valid(result_valid),
		.result_kind(result_kind), .out_status(out_status),
		.out_data_one(out_data_one), .out_data_two(out_data_two),
		.tempo_us(tempo_us), .queue_count(queue_count), .last(last)
	);

	a_no_start_taken_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request not taken");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctrl.emit_simple, ctrl.emit_msg, ctrl.emit_tempo}) <= 1)
		else $error("two result sources at once");
	a_word_follows_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit_simple || ctrl.flush) |=> result_valid)
		else $error("result word missing");
endmodule

// File: tb/tb_top.sv
// self-checking testbench for the midi timed event dispatcher unit
module tb_top;

	typedef struct {
		logic [1:0] req;
		logic [31:0] now;
		logic [31:0] when;
		logic absolute;
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
		logic meta;
		logic [7:0] mtype;
		logic [23:0] payload;
	} midi_req_t;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
		logic [23:0] tempo;
		logic [4:0] count;
		logic last;
	} midi_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic [1:0] req_type = '0;
	logic [31:0] now_ticks = '0;
	logic [31:0] time_ticks = '0;
	logic is_absolute = 1'b0;
	logic [7:0] status_byte = '0;
	logic [6:0] data_one = '0;
	logic [6:0] data_two = '0;
	logic is_meta = 1'b0;
	logic [7:0] meta_type = '0;
	logic [23:0] meta_payload = '0;
	logic result_valid;
	logic [2:0] result_kind;
	logic [7:0] out_status;
	logic [6:0] out_data_one;
	logic [6:0] out_data_two;
	logic [23:0] tempo_us;
	logic [4:0] queue_count;
	logic last;

	midi_timed_event_dispatcher_unit u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	midi_req_t pending_reqs[$];
	midi_word_t expected_words[$];
	midi_req_t cur;
	bit took;
	bit quiet;
	int gap;
	int errs;

	// shadow of the event queue and scale registers
	logic [31:0] due_shadow[16];
	midi_req_t body_shadow[16];
	int q_head, q_tail, q_count;
	logic [15:0] tempo_div, vel_mul;

	function automatic void push_word(logic [2:0] kind, logic [7:0] st, logic [6:0] d1,
			logic [6:0] d2, logic [23:0] tempo);
		midi_word_t w;
		w.kind = kind;
		w.status = st;
		w.d1 = d1;
		w.d2 = d2;
		w.tempo = tempo;
		w.count = q_count[4:0];
		w.last = 1'b0;
		expected_words.push_back(w);
	endfunction

	function automatic void dispatch_predict(midi_req_t r);
		int n;
		logic [32:0] sum;
		logic [31:0] scaled_p, quot;
		logic [22:0] vel;
		midi_req_t b;
		n = 0;
		if (r.req == mted_pkg::REQ_ENQ) begin
			if (q_count >= 16) begin
				push_word(mted_pkg::KIND_REJECTED, 0, 0, 0, 0);
			end else begin
				sum = {1'b0, r.when} + {1'b0, r.now};
				due_shadow[q_tail] = r.absolute ? r.when : (sum[32] ? 32'hFFFFFFFF : sum[31:0]);
				body_shadow[q_tail] = r;
				q_tail = (q_tail + 1) % 16;
				q_count++;
				push_word(mted_pkg::KIND_ACCEPTED, 0, 0, 0, 0);
			end
			n = 1;
		end else if (r.req == mted_pkg::REQ_TICK) begin
			while (q_count > 0 && n < mted_pkg::MAX_RESULTS && due_shadow[q_head] <= r.now) begin
				b = body_shadow[q_head];
				q_head = (q_head + 1) % 16;
				q_count--;
				if (b.meta) begin
					if (b.mtype == mted_pkg::TEMPO_META) begin
						scaled_p = {b.payload, 8'h00};
						quot = (tempo_div == 0) ? 32'hFFFFFF : scaled_p / tempo_div;
						if (quot > 32'hFFFFFF)
							quot = 32'hFFFFFF;
						push_word(mted_pkg::KIND_TEMPO, 0, 0, 0, quot[23:0]);
						n++;
					end
				end else begin
					if (b.status[7:4] == 4'h8 || b.status[7:4] == 4'h9) begin
						vel = (b.d2 * vel_mul) >> 8;
						push_word(mted_pkg::KIND_MESSAGE, b.status, b.d1,
							(vel > mted_pkg::VEL_MAX) ? mted_pkg::VEL_MAX : vel[6:0], 0);
					end else begin
						push_word(mted_pkg::KIND_MESSAGE, b.status, b.d1, b.d2, 0);
					end
					n++;
				end
			end
		end else if (r.req == mted_pkg::REQ_CLEAR) begin
			q_head = 0;
			q_tail = 0;
			q_count = 0;
			push_word(mted_pkg::KIND_CLEARED, 0, 0, 0, 0);
			n = 1;
		end
		if (n > 0)
			expected_words[expected_words.size() - 1].last = 1'b1;
	endfunction

	// driver: holds a word until taken, inserts random idle bursts unless quiet is set
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !took) begin
			end else begin
				took = 1'b0;
				if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (pending_reqs.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
					gap = $urandom_range(1, 6) - 1;
					start <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur = pending_reqs.pop_front();
					req_type <= cur.req;
					now_ticks <= cur.now;
					time_ticks <= cur.when;
					is_absolute <= cur.absolute;
					status_byte <= cur.status;
					data_one <= cur.d1;
					data_two <= cur.d2;
					is_meta <= cur.meta;
					meta_type <= cur.mtype;
					meta_payload <= cur.payload;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: take-up of request words and checking of result words
	always @(posedge clk) begin
		midi_word_t w;
		if (arst_n) begin
			if (start && !busy) begin
				took = 1'b1;
				dispatch_predict(cur);
			end
			if (result_valid) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word, kind %0d", result_kind);
					errs++;
				end else begin
					w = expected_words.pop_front();
					if (result_kind !== w.kind) begin
						$error("result_kind exp %0d got %0d", w.kind, result_kind); errs++;
					end
					if (out_status !== w.status) begin
						$error("out_status exp %0h got %0h", w.status, out_status); errs++;
					end
					if (out_data_one !== w.d1) begin
						$error("out_data_one exp %0d got %0d", w.d1, out_data_one); errs++;
					end
					if (out_data_two !== w.d2) begin
						$error("out_data_two exp %0d got %0d", w.d2, out_data_two); errs++;
					end
					if (tempo_us !== w.tempo) begin
						$error("tempo_us exp %0h got %0h", w.tempo, tempo_us); errs++;
					end
					if (queue_count !== w.count) begin
						$error("queue_count exp %0d got %0d", w.count, queue_count); errs++;
					end
					if (last !== w.last) begin
						$error("last exp %0b got %0b", w.last, last); errs++;
					end
				end
			end
		end
	end

	function automatic midi_req_t mk_event(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
			logic meta, logic [7:0] mt, logic [23:0] pl, logic abs_t, logic [31:0] t,
			logic [31:0] now);
		midi_req_t r;
		r.req = mted_pkg::REQ_ENQ;
		r.now = now;
		r.when = t;
		r.absolute = abs_t;
		r.status = st;
		r.d1 = d1;
		r.d2 = d2;
		r.meta = meta;
		r.mtype = mt;
		r.payload = pl;
		return r;
	endfunction

	function automatic midi_req_t mk_ctl(logic [1:0] req, logic [31:0] now);
		midi_req_t r;
		r = mk_event(8'($urandom), 7'($urandom), 7'($urandom), 1'($urandom), 8'($urandom),
			24'($urandom), 1'($urandom), $urandom, now);
		r.req = req;
		return r;
	endfunction

	logic [31:0] song_pos;

	function automatic midi_req_t rand_req();
		midi_req_t r;
		int sel;
		logic [7:0] st;
		logic [31:0] t;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			st = ($urandom_range(0, 1)) ? {4'($urandom_range(8, 9)), 4'($urandom)}
				: 8'($urandom);
			t = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
			r = mk_event(st, 7'($urandom), 7'($urandom), $urandom_range(0, 4) == 0,
				$urandom_range(0, 1) ? mted_pkg::TEMPO_META : 8'($urandom), 24'($urandom),
				1'($urandom_range(0, 1)), $urandom_range(0, 1) ? song_pos + t : t,
				($urandom_range(0, 15) == 0) ? $urandom : song_pos);
		end else if (sel < 90) begin
			song_pos = song_pos + $urandom_range(0, 40);
			r = mk_ctl(mted_pkg::REQ_TICK, ($urandom_range(0, 19) == 0) ? $urandom : song_pos);
		end else if (sel < 94) begin
			r = mk_ctl(mted_pkg::REQ_CLEAR, $urandom);
		end else begin
			r = mk_ctl(2'd3, $urandom);
		end
		return r;
	endfunction

	task automatic settle();
		do @(posedge clk);
		while (pending_reqs.size() > 0 || start || busy || expected_words.size() > 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == mted_pkg::CFG_TEMPO_SCALE)
			tempo_div = val;
		else
			vel_mul = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] tsc[6];
		logic [15:0] vsc[6];
		errs = 0;
		gap = 0;
		quiet = 1'b0;
		took = 1'b0;
		q_head = 0;
		q_tail = 0;
		q_count = 0;
		tempo_div = 16'd256;
		vel_mul = 16'd256;
		song_pos = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, note and other messages, tempo and other metas, overflow, full queue, drain limit
		pending_reqs.push_back(mk_ctl(mted_pkg::REQ_CLEAR, 0));
		pending_reqs.push_back(mk_event(8'h90, 7'd127, 7'd127, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_event(8'h8F, 7'd0, 7'd64, 0, 0, 0, 1, 5, 0));
		pending_reqs.push_back(mk_event(8'hB3, 7'd7, 7'd100, 0, 0, 0, 1, 6, 0));
		pending_reqs.push_back(mk_event(8'hFF, 0, 0, 1, mted_pkg::TEMPO_META, 24'hFFFFFF,
			1, 7, 0));
		pending_reqs.push_back(mk_event(8'h00, 0, 0, 1, mted_pkg::TEMPO_META, 24'h000000,
			1, 8, 0));
		pending_reqs.push_back(mk_event(8'hFF, 0, 0, 1, 8'h2F, 24'h123456, 1, 9, 0));
		pending_reqs.push_back(mk_event(8'h91, 7'd60, 7'd1, 0, 0, 0, 0, 32'hFFFFFFF0,
			32'hFFFFFFFF));
		pending_reqs.push_back(mk_ctl(mted_pkg::REQ_TICK, 32'd3));
		pending_reqs.push_back(mk_ctl(mted_pkg::REQ_TICK, 32'hFFFFFFFE));
		pending_reqs.push_back(mk_ctl(mted_pkg::REQ_TICK, 32'hFFFFFFFF));
		pending_reqs.push_back(mk_ctl(2'd3, 32'hFFFFFFFF));
		for (int i = 0; i < 17; i++)
			pending_reqs.push_back(mk_event(8'h90 | i[3:0], i[6:0], 7'd90, 0, 0, 0, 1, 0, 0));
		pending_reqs.push_back(mk_ctl(mted_pkg::REQ_TICK, 0));
		settle();

		tsc = '{16'd0, 16'd65535, 16'd1, 16'd256, 16'd0, 16'd3};
		vsc = '{16'd65535, 16'd0, 16'd1, 16'd512, 16'd0, 16'd300};
		tsc[4] = 16'($urandom);
		vsc[4] = 16'($urandom);
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(mted_pkg::CFG_TEMPO_SCALE, tsc[ph]);
			write_reg(mted_pkg::CFG_VELOCITY_SCALE, vsc[ph]);
			if (ph == 5)
				quiet = 1'b1;
			for (int i = 0; i < 80; i++)
				pending_reqs.push_back(rand_req());
			// drain what is due, up to 16 words; settle then waits for every result
			pending_reqs.push_back(mk_ctl(mted_pkg::REQ_TICK, 32'hFFFFFFFF));
			settle();
		end

		if (errs == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
